[design/cartridge_rtc_mapper_registers_assert.svh]
// Assertion macros shared by the clock and mapper register block.
// Depends on nothing; files that check their logic include it by name.
`ifndef CARTRIDGE_RTC_MAPPER_REGISTERS_ASSERT_SVH
`define CARTRIDGE_RTC_MAPPER_REGISTERS_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge out of reset.
`define CRTC_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define CRTC_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next-cycle check failed");

`else

`define CRTC_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define CRTC_ASSERT_NXT(label, clk, rst_n, cond, prop)

`endif

`endif

[design/crtc_pkg.sv]
// Shared types and constants of the clock and mapper register block.
// Used by every module of the block; depends on nothing.
package crtc_pkg;

    // Item opcodes.
    typedef enum logic [2:0] {
        OP_READ       = 3'd0,
        OP_WRITE      = 3'd1,
        OP_LATCH      = 3'd2,
        OP_SET_TIME   = 3'd3,
        OP_HALT       = 3'd4,
        OP_RESUME     = 3'd5,
        OP_SET_RUMBLE = 3'd6
    } op_t;

    // Steps of the elapsed-time splitter: estimate, multiply back, fix up.
    typedef enum logic [3:0] {
        SPL_IDLE,
        SPL_WQ,
        SPL_WP,
        SPL_WF,
        SPL_HQ,
        SPL_HP,
        SPL_HF,
        SPL_MQ,
        SPL_MP,
        SPL_MF
    } spl_state_t;

    // Splitter status seen by the core.
    typedef struct packed {
        logic busy;
        logic done;
    } crtc_split_stat_t;

    // Time fields produced by one latch, plus the amount folded into the base.
    typedef struct packed {
        logic [7:0]  week;
        logic [7:0]  day_hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic [31:0] fold;
    } crtc_split_res_t;

    // Time constants in seconds.
    localparam logic [31:0] SECS_256_WEEKS = 32'd154828800;
    localparam logic [31:0] SECS_WEEK      = 32'd604800;
    localparam logic [31:0] SECS_DAY       = 32'd86400;
    localparam logic [31:0] SECS_HOUR      = 32'd3600;
    localparam logic [31:0] SECS_MINUTE    = 32'd60;

    // Reciprocals for the divisions after the low zero bits are shifted out:
    // weeks use (t >> 7) / 4725, hours (t >> 4) / 225, minutes (t >> 2) / 15.
    localparam logic [12:0] RECIP_WEEK   = 13'd7101;
    localparam logic [12:0] RECIP_HOUR   = 13'd291;
    localparam logic [12:0] RECIP_MINUTE = 13'd68;
    localparam logic [7:0]  HOURS_PER_DAY = 8'd24;

    // Register byte masks.
    localparam logic [7:0] STATUS_HIGH   = 8'hF0;
    localparam logic [7:0] DAY_MASK      = 8'hE0;
    localparam logic [7:0] HOUR_MASK     = 8'h1F;
    localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;

    // Register maps and the registers inside them.
    localparam logic [3:0] MAP_BANK  = 4'd0;
    localparam logic [3:0] MAP_CLOCK = 4'd3;
    localparam logic [1:0] IDX_ROM_LO   = 2'd0;
    localparam logic [1:0] IDX_ROM_HI   = 2'd1;
    localparam logic [1:0] IDX_RAM      = 2'd2;
    localparam logic [1:0] IDX_STATUS   = 2'd3;
    localparam logic [1:0] IDX_WEEK     = 2'd0;
    localparam logic [1:0] IDX_DAY_HOUR = 2'd1;
    localparam logic [1:0] IDX_MINUTE   = 2'd2;
    localparam logic [1:0] IDX_SECOND   = 2'd3;

    // Configuration register index, taken from paddr bit 2.
    localparam logic CFG_INDEX_FEATURE = 1'b0;

endpackage

[design/crtc_split.sv]
// Elapsed-time splitter: weeks, day and hour, minutes and seconds.
// Uses crtc_pkg; one shared multiplier stepped by a small sequencer.
module crtc_split (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [31:0]                elapsed,
    output crtc_pkg::crtc_split_stat_t stat,
    output crtc_pkg::crtc_split_res_t  res
);
    import crtc_pkg::*;

    spl_state_t  state_reg;
    spl_state_t  state_next;
    logic [31:0] work_reg;
    logic [12:0] quot_reg;
    logic [31:0] prod_reg;
    logic [12:0] weeks_reg;
    logic [7:0]  hours_reg;
    logic [31:0] fold_reg;

    logic [24:0] mul_a;
    logic [19:0] mul_b;
    logic [44:0] mul_full;
    logic [12:0] q_est;
    logic [31:0] div_c;
    logic [31:0] rem;
    logic        rem_ge;
    logic [31:0] rem_fix;
    logic [12:0] q_fix;

    // Hours within a week (below 168) to the packed day and hour byte.
    function automatic logic [7:0] pack_day_hour(input logic [7:0] hours);
        logic [2:0] day;
        logic [7:0] rest;
        day  = 3'd0;
        rest = hours;
        for (int i = 0; i < 6; i++) begin
            if (rest >= HOURS_PER_DAY) begin
                rest = rest - HOURS_PER_DAY;
                day  = day + 3'd1;
            end
        end
        return {day, rest[4:0]};
    endfunction

    // Next step of the sequencer.
    always_comb
    begin
        unique case (state_reg)
            SPL_IDLE: state_next = start ? SPL_WQ : SPL_IDLE;
            SPL_WQ:   state_next = SPL_WP;
            SPL_WP:   state_next = SPL_WF;
            SPL_WF:   state_next = SPL_HQ;
            SPL_HQ:   state_next = SPL_HP;
            SPL_HP:   state_next = SPL_HF;
            SPL_HF:   state_next = SPL_MQ;
            SPL_MQ:   state_next = SPL_MP;
            SPL_MP:   state_next = SPL_MF;
            SPL_MF:   state_next = SPL_IDLE;
            default:  state_next = SPL_IDLE;
        endcase
    end

    // Multiplier operands and divisor for each step.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        div_c = SECS_MINUTE;
        unique case (state_reg)
            SPL_WQ:
            begin
                mul_a = work_reg[31:7];
                mul_b = {7'd0, RECIP_WEEK};
            end
            SPL_WP:
            begin
                mul_a = {12'd0, quot_reg};
                mul_b = SECS_WEEK[19:0];
            end
            SPL_WF:   div_c = SECS_WEEK;
            SPL_HQ:
            begin
                mul_a = {9'd0, work_reg[19:4]};
                mul_b = {7'd0, RECIP_HOUR};
            end
            SPL_HP:
            begin
                mul_a = {12'd0, quot_reg};
                mul_b = SECS_HOUR[19:0];
            end
            SPL_HF:   div_c = SECS_HOUR;
            SPL_MQ:
            begin
                mul_a = {15'd0, work_reg[11:2]};
                mul_b = {7'd0, RECIP_MINUTE};
            end
            SPL_MP:
            begin
                mul_a = {12'd0, quot_reg};
                mul_b = SECS_MINUTE[19:0];
            end
            SPL_MF:   div_c = SECS_MINUTE;
            default:  div_c = SECS_MINUTE;
        endcase
    end

    // The shared multiplier.
    assign mul_full = {20'd0, mul_a} * {25'd0, mul_b};

    // Quotient estimate: the product shifted by the reciprocal's scale.
    always_comb
    begin
        unique case (state_reg)
            SPL_WQ:  q_est = mul_full[37:25];
            SPL_HQ:  q_est = mul_full[28:16];
            SPL_MQ:  q_est = mul_full[22:10];
            default: q_est = '0;
        endcase
    end

    // The estimate is at most one short, so one compare and subtract fixes it.
    assign rem     = work_reg - prod_reg;
    assign rem_ge  = (rem >= div_c);
    assign rem_fix = rem_ge ? (rem - div_c) : rem;
    assign q_fix   = quot_reg + {12'd0, rem_ge};

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SPL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            SPL_IDLE:
            begin
                if (start)
                begin
                    work_reg <= elapsed;
                end
            end
            SPL_WQ, SPL_MQ:
            begin
                quot_reg <= q_est;
            end
            SPL_HQ:
            begin
                quot_reg <= q_est;
                fold_reg <= {27'd0, weeks_reg[12:8]} * SECS_256_WEEKS;
            end
            SPL_WP, SPL_HP, SPL_MP:
            begin
                prod_reg <= mul_full[31:0];
            end
            SPL_WF:
            begin
                work_reg  <= rem_fix;
                weeks_reg <= q_fix;
            end
            SPL_HF:
            begin
                work_reg  <= rem_fix;
                hours_reg <= q_fix[7:0];
            end
            default:
            begin
            end
        endcase
    end

    // Results are complete during the last fix-up step.
    assign stat.busy    = (state_reg != SPL_IDLE);
    assign stat.done    = (state_reg == SPL_MF);
    assign res.week     = weeks_reg[7:0];
    assign res.day_hour = pack_day_hour(hours_reg);
    assign res.minute   = {2'd0, q_fix[5:0]};
    assign res.second   = {2'd0, rem_fix[5:0]};
    assign res.fold     = fold_reg;

endmodule

[design/crtc_core.sv]
// Input register, clock state and opcode execution of the register block.
// Uses crtc_pkg and crtc_split; assertion macros come from the shared header.
`include "cartridge_rtc_mapper_registers_assert.svh"

module crtc_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  feature_bits,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [31:0] now_seconds,
    input  logic [3:0]  map_select,
    input  logic [15:0] rom_bank,
    input  logic [7:0]  ram_bank,
    input  logic [1:0]  reg_index,
    input  logic [7:0]  write_data,
    input  logic [7:0]  rumble_level,
    input  logic        space,
    output logic        push,
    output logic [7:0]  push_data
);
    import crtc_pkg::*;

    // Input register.
    logic        item_valid_reg;
    logic        item_valid_next;
    logic [2:0]  opcode_reg;
    logic [31:0] now_reg;
    logic [3:0]  map_reg;
    logic [15:0] rom_reg;
    logic [7:0]  ram_reg;
    logic [1:0]  index_reg;
    logic [7:0]  wdata_reg;
    logic [7:0]  level_reg;

    // Clock and mapper state.
    logic [31:0] base_reg;
    logic [31:0] base_next;
    logic [31:0] halted_reg;
    logic [31:0] halted_next;
    logic [7:0]  week_reg;
    logic [7:0]  week_next;
    logic [7:0]  day_hour_reg;
    logic [7:0]  day_hour_next;
    logic [7:0]  minute_reg;
    logic [7:0]  minute_next;
    logic [7:0]  second_reg;
    logic [7:0]  second_next;
    logic [7:0]  rumble_reg;
    logic [7:0]  rumble_next;
    logic        running_reg;
    logic        running_next;
    logic        overflow_reg;
    logic        overflow_next;

    logic             in_accept;
    logic             exec_fire;
    logic             split_start;
    crtc_split_stat_t split_stat;
    crtc_split_res_t  split_res;
    logic [31:0]      time_src;
    logic [31:0]      span;
    logic [7:0]       hour_field;
    logic [7:0]       read_byte;
    op_t              op;

    // The item executes once the splitter is free and the output has room.
    assign exec_fire       = item_valid_reg && !split_stat.busy && space;
    assign in_ready        = !item_valid_reg || exec_fire;
    assign in_accept       = in_valid && in_ready;
    assign item_valid_next = in_accept || (item_valid_reg && !exec_fire);
    assign op              = op_t'(opcode_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            opcode_reg <= opcode;
            now_reg    <= now_seconds;
            map_reg    <= map_select;
            rom_reg    <= rom_bank;
            ram_reg    <= ram_bank;
            index_reg  <= reg_index;
            wdata_reg  <= write_data;
            level_reg  <= rumble_level;
        end
    end

    // Time source and the span held in the four time bytes.
    assign time_src   = running_reg ? now_reg : halted_reg;
    assign hour_field = day_hour_reg & HOUR_MASK;
    assign span = {24'd0, second_reg}
                + {24'd0, minute_reg} * SECS_MINUTE
                + {24'd0, hour_field} * SECS_HOUR
                + {29'd0, day_hour_reg[7:5]} * SECS_DAY
                + {24'd0, week_reg} * SECS_WEEK;

    // Register read byte.
    always_comb
    begin
        if (map_reg == MAP_BANK)
        begin
            unique case (index_reg)
                IDX_ROM_LO: read_byte = rom_reg[7:0];
                IDX_ROM_HI: read_byte = rom_reg[15:8];
                IDX_RAM:    read_byte = ram_reg;
                default:    read_byte = STATUS_HIGH
                                      | {4'd0, overflow_reg, running_reg, rumble_reg[1:0]};
            endcase
        end
        else if (map_reg == MAP_CLOCK)
        begin
            unique case (index_reg)
                IDX_WEEK:     read_byte = week_reg;
                IDX_DAY_HOUR: read_byte = day_hour_reg;
                IDX_MINUTE:   read_byte = minute_reg;
                default:      read_byte = second_reg;
            endcase
        end
        else
        begin
            read_byte = UNMAPPED_BYTE;
        end
    end

    // Opcode execution and the writeback of a finished latch.
    always_comb
    begin
        base_next     = base_reg;
        halted_next   = halted_reg;
        week_next     = week_reg;
        day_hour_next = day_hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;
        rumble_next   = rumble_reg;
        running_next  = running_reg;
        overflow_next = overflow_reg;
        split_start   = 1'b0;
        push_data     = 8'd0;
        if (split_stat.done)
        begin
            week_next     = split_res.week;
            day_hour_next = split_res.day_hour;
            minute_next   = split_res.minute;
            second_next   = split_res.second;
            base_next     = base_reg + split_res.fold;
            if (split_res.fold != 32'd0)
            begin
                overflow_next = 1'b1;
            end
        end
        else if (exec_fire)
        begin
            unique case (op)
                OP_READ:
                begin
                    push_data = read_byte;
                end
                OP_WRITE:
                begin
                    if (map_reg == MAP_CLOCK)
                    begin
                        unique case (index_reg)
                            IDX_WEEK:     week_next     = wdata_reg;
                            IDX_DAY_HOUR: day_hour_next = wdata_reg;
                            IDX_MINUTE:   minute_next   = wdata_reg;
                            default:      second_next   = wdata_reg;
                        endcase
                    end
                end
                OP_LATCH:
                begin
                    split_start = 1'b1;
                end
                OP_SET_TIME:
                begin
                    base_next = time_src - span;
                end
                OP_HALT:
                begin
                    if (running_reg)
                    begin
                        halted_next  = now_reg;
                        running_next = 1'b0;
                    end
                end
                OP_RESUME:
                begin
                    if (!running_reg)
                    begin
                        base_next    = base_reg + (now_reg - halted_reg);
                        running_next = 1'b1;
                    end
                end
                OP_SET_RUMBLE:
                begin
                    if (feature_bits[0])
                    begin
                        rumble_next = feature_bits[1] ? level_reg
                                                      : {7'd0, (level_reg != 8'd0)};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign push = exec_fire;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            halted_reg   <= '0;
            week_reg     <= '0;
            day_hour_reg <= '0;
            minute_reg   <= '0;
            second_reg   <= '0;
            rumble_reg   <= '0;
            running_reg  <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            base_reg     <= base_next;
            halted_reg   <= halted_next;
            week_reg     <= week_next;
            day_hour_reg <= day_hour_next;
            minute_reg   <= minute_next;
            second_reg   <= second_next;
            rumble_reg   <= rumble_next;
            running_reg  <= running_next;
            overflow_reg <= overflow_next;
        end
    end

    // The latch splitter runs on the elapsed time of this item.
    crtc_split u_split (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (split_start),
        .elapsed (time_src - base_reg),
        .stat    (split_stat),
        .res     (split_res)
    );

    // A latch starts only on an idle splitter and occupies it the next cycle.
    `CRTC_ASSERT_IMP(a_start_idle, clk, rst_n, split_start, !split_stat.busy)
    `CRTC_ASSERT_NXT(a_start_busy, clk, rst_n, split_start, split_stat.busy)
    // The overflow flag never clears once set.
    `CRTC_ASSERT_NXT(a_overflow_sticky, clk, rst_n, overflow_reg, overflow_reg)
    // The clock starts running only through an executed resume.
    `CRTC_ASSERT_IMP(a_run_by_resume, clk, rst_n, $rose(running_reg), $past(exec_fire) && ($past(opcode_reg) == OP_RESUME))

endmodule

[design/crtc_out_fifo.sv]
// Two-entry result buffer between execution and the output channel.
// Uses crtc_pkg; assertion macros come from the shared header.
`include "cartridge_rtc_mapper_registers_assert.svh"

module crtc_out_fifo (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] push_data,
    output logic       space,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data
);
    import crtc_pkg::*;

    logic [7:0] data_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    // Room is judged on the stored count alone, so no path runs from out_ready.
    assign space     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign read_data = data_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and occupancy updates.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    // No push into a full buffer, and the count stays within two.
    `CRTC_ASSERT_IMP(a_no_overrun, clk, rst_n, push, count_reg != 2'd2)
    `CRTC_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg <= 2'd2)
    // Taking the last entry with nothing arriving leaves the buffer empty.
    `CRTC_ASSERT_NXT(a_drain, clk, rst_n, pop && !push && (count_reg == 2'd1), !out_valid)

endmodule

[design/cartridge_rtc_mapper_registers.sv]
// A result passes the input register, then a two-entry result buffer, before
// it can be taken. Throughput: one item per cycle for read, write, set time,
// halt, resume and set rumble while the splitter is idle and the buffer has
// room. A latch holds the execute stage for its start plus nine splitter steps.
// Reset (rst_n low, asynchronous) clears the clock state, base and halt time,
// flags, rumble level, feature register and result buffer; no clearing pass.
// Top level: APB feature register, execution core and result buffer.
// Uses crtc_pkg, crtc_core and crtc_out_fifo.
module cartridge_rtc_mapper_registers (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [31:0] now_seconds,
    input  logic [3:0]  map_select,
    input  logic [15:0] rom_bank,
    input  logic [7:0]  ram_bank,
    input  logic [1:0]  reg_index,
    input  logic [7:0]  write_data,
    input  logic [7:0]  rumble_level,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data
);
    import crtc_pkg::*;

    logic [1:0] feature_bits_reg;
    logic [1:0] feature_bits_next;
    logic       cfg_write;
    logic       push;
    logic [7:0] push_data;
    logic       space;

    // Configuration port: writes complete in the access cycle, reads are direct.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign feature_bits_next = (cfg_write && (paddr[2] == CFG_INDEX_FEATURE))
                             ? pwdata[1:0] : feature_bits_reg;
    assign prdata = (paddr[2] == CFG_INDEX_FEATURE) ? {30'd0, feature_bits_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feature_bits_reg <= 2'd0;
        end
        else
        begin
            feature_bits_reg <= feature_bits_next;
        end
    end

    // Execution core with the clock state.
    crtc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .feature_bits (feature_bits_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .now_seconds  (now_seconds),
        .map_select   (map_select),
        .rom_bank     (rom_bank),
        .ram_bank     (ram_bank),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .rumble_level (rumble_level),
        .space        (space),
        .push         (push),
        .push_data    (push_data)
    );

    // Result buffer toward the output channel.
    crtc_out_fifo u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data)
    );

endmodule
